// ===== src/ffba_pkg.sv =====
// shared types and constants of the first-fit block allocator
package ffba_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_ADDR_BITS   = 16;

    localparam int SIZE_W     = 17;
    localparam int OWNER_W    = 8;
    localparam int OUT_ADDR_W = 16;
    localparam int STATUS_W   = 2;
    localparam int POOL_W     = 17;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // command class decided by the front end
    typedef enum logic [1:0] {
        KIND_ALLOC,
        KIND_RELEASE,
        KIND_NOFIT,
        KIND_NOTFOUND
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SIZE_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
    } cmd_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

// ===== src/first_fit_block_allocator_top.sv =====
// top level of the first-fit block allocator: front end, command queue, back end
//
// a request is taken when start is high and busy is low; each request gives
// exactly one result, shown on start_address and status for one cycle with
// done high, and the receiver cannot stall it, so it must take every result
// in the cycle it appears; results come in request order; an allocate or
// release that scans the table reads k table entries before its result,
// where k is at most the entry count, so at most MAX_ENTRIES; a split
// allocate holds the back end in its append state to add the free
// remainder, while its own result is not delayed; the scan walks the single
// read port of the block table memory one entry per cycle; a zero-size
// allocate and a release with owner tag 0 need no scan and get their result
// straight from the idle state; the queue holds two requests, so busy rises
// only when two are waiting; pool_size is written over the cfg channel only
// while the block is idle (cfg_ready high), and the write resets the table to
// one free block covering the pool; no clearing pass is needed after reset,
// since the table is tracked by its entry count
module first_fit_block_allocator_top import ffba_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [SIZE_W-1:0]     alloc_size,
    input  logic [OWNER_W-1:0]    owner_id,
    // pool size register write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [POOL_W-1:0]     pool_size,
    // result strobe
    output logic                  done,
    output logic [OUT_ADDR_W-1:0] start_address,
    output logic [STATUS_W-1:0]   status
);

    logic                 q_full;
    logic                 push;
    cmd_t                 push_cmd;
    logic                 pop;
    q_head_t              head;
    logic [ADDR_BITS-1:0] addr;

    // classify each transfer on the request channel
    ffba_front u_front
    (
        .start      (start),
        .func       (func),
        .alloc_size (alloc_size),
        .owner_id   (owner_id),
        .q_full     (q_full),
        .busy       (busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouples request acceptance from the table scan
    ffba_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    // table memory and scan engine
    ffba_back
    #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .pool_size (pool_size),
        .done      (done),
        .addr      (addr),
        .status    (status)
    );

    // block addresses stay below the address span; the port shows the low 16 bits
    assign start_address = OUT_ADDR_W'(addr);

endmodule

// ===== src/ffba_front.sv =====
// front end: takes requests and sorts out those that need no table scan
module ffba_front import ffba_pkg::*;
(
    input  logic               start,
    input  logic               func,
    input  logic [SIZE_W-1:0]  alloc_size,
    input  logic [OWNER_W-1:0] owner_id,
    input  logic               q_full,
    output logic               busy,
    output logic               push,
    output cmd_t               push_cmd
);

    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        push_cmd.size  = alloc_size;
        push_cmd.owner = owner_id;
        if (func == FUNC_ALLOC)
        begin
            // zero-size request can never be served
            push_cmd.kind = (alloc_size == '0) ? KIND_NOFIT : KIND_ALLOC;
        end
        else
        begin
            // unnamed owner never matches
            push_cmd.kind = (owner_id == '0) ? KIND_NOTFOUND : KIND_RELEASE;
        end
    end

endmodule

// ===== src/ffba_queue.sv =====
// two-entry command queue between front and back end
module ffba_queue import ffba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/ffba_back.sv =====
// back end: block table memory and the first-fit scan engine
module ffba_back import ffba_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_head_t               head,
    output logic                  pop,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [POOL_W-1:0]     pool_size,
    output logic                  done,
    output logic [ADDR_BITS-1:0]  addr,
    output logic [STATUS_W-1:0]   status
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W = (ADDR_BITS + 1 > SIZE_W) ? ADDR_BITS + 1 : SIZE_W;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     length;
        logic                 used;
        logic [OWNER_W-1:0]   owner;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND
    } state_t;

    localparam logic [LEN_W-1:0] SPAN = LEN_W'(1) << ADDR_BITS;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [IDX_W-1:0]     ev_idx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 fresh0_reg;
    logic [LEN_W-1:0]     pool_reg;
    logic [ADDR_BITS-1:0] hit_start_reg;
    logic [LEN_W-1:0]     hit_len_reg;
    logic                 done_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [STATUS_W-1:0]  status_reg;

    entry_t           cur;
    logic [LEN_W-1:0] size_ext;
    logic [LEN_W-1:0] pool_in;
    logic [LEN_W-1:0] pool_clamped;
    logic             is_alloc;
    logic             fits;
    logic             exact;
    logic             rel_hit;
    logic             hit;
    logic             last;
    logic             table_full;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             cfg_write;

    assign done   = done_reg;
    assign addr   = addr_reg;
    assign status = status_reg;

    assign cfg_ready = (state_reg == S_IDLE) && !head.valid;
    assign cfg_write = cfg_valid && cfg_ready;
    assign pop       = (state_reg == S_IDLE) && head.valid;

    // zero becomes one, anything past the address span is clipped
    always_comb
    begin
        pool_in = LEN_W'(pool_size);
        if (pool_in == '0)
        begin
            pool_clamped = LEN_W'(1);
        end
        else if (pool_in > SPAN)
        begin
            pool_clamped = SPAN;
        end
        else
        begin
            pool_clamped = pool_in;
        end
    end

    // entry 0 reads as the whole free pool until it is first written
    always_comb
    begin
        if (fresh0_reg && ev_idx_reg == '0)
        begin
            cur.start  = '0;
            cur.length = pool_reg;
            cur.used   = 1'b0;
            cur.owner  = '0;
        end
        else
        begin
            cur = rd_data_reg;
        end
    end

    assign size_ext   = LEN_W'(cmd_reg.size);
    assign is_alloc   = (cmd_reg.kind == KIND_ALLOC);
    assign fits       = !cur.used && (cur.length >= size_ext);
    assign exact      = (cur.length == size_ext);
    assign rel_hit    = cur.used && (cur.owner == cmd_reg.owner);
    assign hit        = is_alloc ? fits : rel_hit;
    assign last       = (CNT_W'(ev_idx_reg) + CNT_W'(1)) >= count_reg;
    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));

    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = ev_idx_reg;
        wr_data = cur;
        case (state_reg)
            S_SCAN:
            begin
                rd_addr = ev_idx_reg + IDX_W'(1);
                if (hit)
                begin
                    if (is_alloc)
                    begin
                        wr_en          = exact || !table_full;
                        wr_data.length = size_ext;
                        wr_data.used   = 1'b1;
                        wr_data.owner  = cmd_reg.owner;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data.used  = 1'b0;
                        wr_data.owner = '0;
                    end
                end
            end
            S_APPEND:
            begin
                // free remainder of the split goes to the end of the table
                wr_en          = 1'b1;
                wr_addr        = count_reg[IDX_W-1:0];
                wr_data.start  = ADDR_BITS'(LEN_W'(hit_start_reg) + size_ext);
                wr_data.length = hit_len_reg - size_ext;
                wr_data.used   = 1'b0;
                wr_data.owner  = '0;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            ev_idx_reg    <= '0;
            count_reg     <= CNT_W'(1);
            fresh0_reg    <= 1'b1;
            pool_reg      <= (LEN_W'(1 << 16) > SPAN) ? SPAN : LEN_W'(1 << 16);
            hit_start_reg <= '0;
            hit_len_reg   <= '0;
            done_reg      <= 1'b0;
            addr_reg      <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                pool_reg   <= pool_clamped;
                count_reg  <= CNT_W'(1);
                fresh0_reg <= 1'b1;
            end
            if (wr_en && wr_addr == '0)
            begin
                fresh0_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        cmd_reg    <= head.cmd;
                        ev_idx_reg <= '0;
                        case (head.cmd.kind)
                            KIND_NOFIT:
                            begin
                                done_reg   <= 1'b1;
                                addr_reg   <= '0;
                                status_reg <= ST_NOFIT;
                            end
                            KIND_NOTFOUND:
                            begin
                                done_reg   <= 1'b1;
                                addr_reg   <= '0;
                                status_reg <= ST_NOTFOUND;
                            end
                            default:
                            begin
                                state_reg <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                        if (!is_alloc)
                        begin
                            addr_reg   <= '0;
                            status_reg <= ST_OK;
                        end
                        else if (exact)
                        begin
                            addr_reg   <= cur.start;
                            status_reg <= ST_OK;
                        end
                        else if (table_full)
                        begin
                            addr_reg   <= '0;
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            addr_reg      <= cur.start;
                            status_reg    <= ST_OK;
                            hit_start_reg <= cur.start;
                            hit_len_reg   <= cur.length;
                            state_reg     <= S_APPEND;
                        end
                    end
                    else if (last)
                    begin
                        done_reg   <= 1'b1;
                        addr_reg   <= '0;
                        status_reg <= is_alloc ? ST_NOFIT : ST_NOTFOUND;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        ev_idx_reg <= ev_idx_reg + IDX_W'(1);
                    end
                end
                S_APPEND:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb_first_fit_block_allocator_top.sv =====
// self-checking testbench of the first-fit block allocator top level
module tb_first_fit_block_allocator_top;
    import ffba_pkg::*;

    // table depth and address span of the instance under test
    localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
    localparam int POOL_MAX    = 1 << DEF_ADDR_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 50;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 78;

    // one result as the block shows it on done
    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        logic [STATUS_W-1:0]   code;
    } grant_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  func;
    logic [SIZE_W-1:0]     alloc_size;
    logic [OWNER_W-1:0]    owner_id;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [POOL_W-1:0]     pool_size;
    logic                  done;
    logic [OUT_ADDR_W-1:0] start_address;
    logic [STATUS_W-1:0]   status;

    // private copy of the block table, updated at each accepted transfer
    logic [POOL_W-1:0]     pool_bytes;
    logic [OUT_ADDR_W-1:0] blk_start [TABLE_DEPTH];
    logic [SIZE_W-1:0]     blk_len   [TABLE_DEPTH];
    logic                  blk_used  [TABLE_DEPTH];
    logic [OWNER_W-1:0]    blk_owner [TABLE_DEPTH];
    int                    blk_count;

    // results still owed by the block, oldest first
    grant_t grant_queue[$];

    int  error_count;
    int  cycle_count;
    int  pool_writes;
    int  grants_by_code [4];
    bit  gaps_on;

    // 8 time unit clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    first_fit_block_allocator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .alloc_size    (alloc_size),
        .owner_id      (owner_id),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .pool_size     (pool_size),
        .done          (done),
        .start_address (start_address),
        .status        (status)
    );

    // run guard: a hung block ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, grant_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    // one line per mismatch, printing capped, counting never
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("cycle %0d: mismatch: %s", cycle_count, msg);
        error_count++;
    endtask

    // table back to one free block over the whole pool
    function automatic void clear_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            blk_start[i] = '0;
            blk_len[i]   = '0;
            blk_used[i]  = 1'b0;
            blk_owner[i] = '0;
        end
        blk_len[0] = pool_bytes;
        blk_count  = 1;
    endfunction

    // first-fit allocate or owner release against the private table
    function automatic grant_t apply_request(input logic op,
                                             input logic [SIZE_W-1:0] size,
                                             input logic [OWNER_W-1:0] tag);
        grant_t g;
        int     n;
        bit     found;
        g.addr = '0;
        found  = 1'b0;
        if (op == FUNC_ALLOC)
        begin
            g.code = ST_NOFIT;
            // zero-size request never takes a block
            if (size != 0)
            begin
                for (int i = 0; i < blk_count; i++)
                begin
                    if (!found && !blk_used[i] && blk_len[i] >= size)
                    begin
                        // only the first fitting free block is considered
                        found = 1'b1;
                        if (blk_len[i] == size)
                        begin
                            blk_used[i]  = 1'b1;
                            blk_owner[i] = tag;
                            g.addr       = blk_start[i];
                            g.code       = ST_OK;
                        end
                        else if (blk_count >= TABLE_DEPTH)
                        begin
                            g.code = ST_FULL;
                        end
                        else
                        begin
                            // remainder goes to the end of the table
                            n            = blk_count;
                            blk_start[n] = blk_start[i] + size[OUT_ADDR_W-1:0];
                            blk_len[n]   = blk_len[i] - size;
                            blk_used[n]  = 1'b0;
                            blk_owner[n] = '0;
                            blk_count    = n + 1;
                            blk_len[i]   = size;
                            blk_used[i]  = 1'b1;
                            blk_owner[i] = tag;
                            g.addr       = blk_start[i];
                            g.code       = ST_OK;
                        end
                    end
                end
            end
        end
        else
        begin
            g.code = ST_NOTFOUND;
            // tag zero is never matched
            if (tag != 0)
            begin
                for (int i = 0; i < blk_count; i++)
                begin
                    if (!found && blk_used[i] && blk_owner[i] == tag)
                    begin
                        found        = 1'b1;
                        blk_used[i]  = 1'b0;
                        blk_owner[i] = '0;
                        g.code       = ST_OK;
                    end
                end
            end
        end
        return g;
    endfunction

    // result checker: every done cycle is one transfer, matched to the oldest grant
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (grant_queue.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: addr %0d status %0d",
                                          start_address, status));
            end
            else
            begin
                want = grant_queue.pop_front();
                grants_by_code[want.code]++;
                if (start_address !== want.addr)
                    report_mismatch($sformatf("start_address %0d, expected %0d",
                                              start_address, want.addr));
                if (status !== want.code)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.code));
            end
        end
    end

    // lower start so nothing more is offered
    task automatic stop_requests();
        @(negedge clk);
        start = 1'b0;
    endtask

    // one request transfer; start stays high afterwards so back-to-back items
    // keep it up, and the next caller lowers it if it needs to
    task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                                input logic [OWNER_W-1:0] tag);
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        @(negedge clk);
        start      = 1'b1;
        func       = op;
        alloc_size = size;
        owner_id   = tag;
        // busy read right after the edge is the value the block saw
        do @(posedge clk); while (busy !== 1'b0);
        grant_queue.insert(grant_queue.size(), apply_request(op, size, tag));
    endtask

    // pool size write, only once every owed result has come back
    task automatic write_pool_size(input logic [POOL_W-1:0] value);
        stop_requests();
        wait (grant_queue.size() == 0);
        repeat (4) @(posedge clk);
        if (gaps_on)
            repeat ($urandom_range(0, 6)) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        pool_size = value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        // out-of-range values are clamped into 1 .. full address span
        if (value == 0)
            pool_bytes = POOL_W'(1);
        else if (value > POOL_MAX)
            pool_bytes = POOL_W'(POOL_MAX);
        else
            pool_bytes = value;
        clear_table();
        pool_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // corners of the fields on the reset pool of 65536 bytes
    task automatic test_field_corners();
        send_request(FUNC_ALLOC, 17'd0, 8'd1);          // zero size never fits
        send_request(FUNC_RELEASE, 17'd0, 8'd0);        // tag zero never found
        send_request(FUNC_ALLOC, 17'h1FFFF, 8'hFF);     // larger than any pool
        send_request(FUNC_ALLOC, 17'h10000, 8'hFF);     // whole pool, exact fit
        send_request(FUNC_ALLOC, 17'd1, 8'd2);          // nothing free left
        send_request(FUNC_RELEASE, 17'h1FFFF, 8'hFF);   // frees the pool
        send_request(FUNC_RELEASE, 17'd0, 8'hFF);       // a free block is never matched
        send_request(FUNC_ALLOC, 17'd1, 8'd0);          // split, stored with tag zero
        send_request(FUNC_RELEASE, 17'd5, 8'd0);        // tag-zero block stays used
        send_request(FUNC_ALLOC, 17'hFFFF, 8'hAA);      // remainder exact fit at 1
    endtask

    // fill all table entries, then a first fit that needs a split must fail
    // even though a later block would be an exact fit
    task automatic test_table_full();
        write_pool_size(17'd30);
        send_request(FUNC_ALLOC, 17'd10, 8'd200);
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_request(FUNC_ALLOC, 17'd1, 8'(i + 1));
        send_request(FUNC_RELEASE, 17'd0, 8'd200);
        send_request(FUNC_ALLOC, 17'd6, 8'd55);         // block 0 would split: full
        send_request(FUNC_ALLOC, 17'd10, 8'd56);        // block 0 exact fit
        send_request(FUNC_ALLOC, 17'd6, 8'd57);         // last block exact fit
    endtask

    // clamping of written pool sizes at both ends
    task automatic test_pool_limits();
        write_pool_size(17'd0);
        send_request(FUNC_ALLOC, 17'd1, 8'd9);
        send_request(FUNC_ALLOC, 17'd1, 8'd9);
        write_pool_size(17'h1FFFF);
        send_request(FUNC_ALLOC, 17'h10000, 8'd3);
        write_pool_size(17'h10001);
        send_request(FUNC_ALLOC, 17'h10001, 8'd3);
    endtask

    // random traffic: mostly well-formed allocate/release runs with a small
    // owner set and sizes on a common unit so freed blocks get reused,
    // plus some fully random noise
    task automatic test_random_traffic();
        logic [POOL_W-1:0] pool_pick;
        int                eff;
        int                unit;
        int                r;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // the last stretch runs with no idling
            gaps_on = (ph < PHASES - 2);
            case (ph % 6)
                0: pool_pick = 17'h10000;
                1: pool_pick = POOL_W'($urandom_range(1, 16));
                2: pool_pick = POOL_W'($urandom_range(17, 1000));
                3: pool_pick = POOL_W'($urandom_range(65537, 131071));
                4: pool_pick = POOL_W'($urandom_range(1000, 65535));
                default: pool_pick = POOL_W'($urandom_range(0, 131071));
            endcase
            write_pool_size(pool_pick);
            eff  = pool_bytes;
            unit = $urandom_range(1, (eff / 24 > 1) ? eff / 24 : 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    send_request(FUNC_ALLOC, 17'd0, OWNER_W'($urandom_range(0, 255)));
                else if (r < 12)
                    send_request(1'($urandom_range(0, 1)),
                                 SIZE_W'($urandom_range(0, 131071)),
                                 OWNER_W'($urandom_range(0, 255)));
                else if (r < 50)
                    send_request(FUNC_RELEASE, SIZE_W'($urandom_range(0, 131071)),
                                 OWNER_W'($urandom_range(0, 6)));
                else
                    send_request(FUNC_ALLOC, SIZE_W'(unit * $urandom_range(1, 4)),
                                 OWNER_W'($urandom_range(0, 19) == 0 ? 0
                                                                    : $urandom_range(1, 6)));
            end
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_ALLOC;
        alloc_size  = '0;
        owner_id    = '0;
        cfg_valid   = 1'b0;
        pool_size   = '0;
        error_count = 0;
        cycle_count = 0;
        pool_writes = 0;
        gaps_on     = 1'b1;
        for (int i = 0; i < 4; i++)
            grants_by_code[i] = 0;
        pool_bytes = POOL_W'(POOL_MAX);
        clear_table();

        // single reset at the start of the run
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_corners();
        test_table_full();
        test_pool_limits();
        test_random_traffic();

        // drain, then let the block run on so that any stray result is still caught
        stop_requests();
        wait (grant_queue.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("checked %0d results over %0d pool size writes",
                 grants_by_code[0] + grants_by_code[1] + grants_by_code[2] + grants_by_code[3],
                 pool_writes);
        $display("ok %0d, no fit %0d, table full %0d, owner not found %0d",
                 grants_by_code[ST_OK], grants_by_code[ST_NOFIT],
                 grants_by_code[ST_FULL], grants_by_code[ST_NOTFOUND]);
        if (error_count == 0 && grant_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== first_fit_block_allocator_top.f =====
src/ffba_pkg.sv
src/ffba_front.sv
src/ffba_queue.sv
src/ffba_back.sv
src/first_fit_block_allocator_top.sv
tb/tb_first_fit_block_allocator_top.sv
